FILE: hw/rtl/gtd_pkg.sv
package gtd_pkg;

   localparam int PIXELS        = 4096;
   localparam int FRACTION_BITS = 4;

   localparam int SLOT_W     = $clog2(PIXELS);
   localparam int NUM_CHAN   = 3;
   localparam int REM_W      = NUM_CHAN * FRACTION_BITS;
   localparam int TBL_DEPTH  = 256;
   localparam int TBL_AW     = $clog2(TBL_DEPTH);
   localparam int TBL_W      = 14;
   localparam int SUM_W      = TBL_W + 1;
   localparam int CHAN_W     = 8;
   localparam int OUT_CHAN_W = 10;
   localparam int CHAN_MAX   = (1 << OUT_CHAN_W) - 1;
   localparam int POS_W      = 11;
   localparam int LANE_W     = 2;
   localparam int IDX_W      = POS_W + LANE_W;
   localparam int FB_W       = 12;
   localparam int WORD_W     = NUM_CHAN * OUT_CHAN_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DITHER_ENABLE = 2'd0,
      CSR_FOUR_ROW_MODE = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [TBL_W-1:0]  data;
   } tbl_wr_type;

   function automatic logic [OUT_CHAN_W-1:0] sat_chan(input logic [SUM_W-1:0] v);
      logic [OUT_CHAN_W-1:0] r;
      if (v > SUM_W'(CHAN_MAX)) begin
         r = OUT_CHAN_W'(CHAN_MAX);
      end else begin
         r = v[OUT_CHAN_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/gtd_gamma_ram.sv
module gtd_gamma_ram
   import gtd_pkg::*;
(
   input  logic              clock,
   input  tbl_wr_type        wr,
   input  logic              rd_en,
   input  logic [TBL_AW-1:0] rd_addr,
   output logic [TBL_W-1:0]  rd_data
);

   logic [TBL_W-1:0] tbl_ram_ff [TBL_DEPTH];
   logic [TBL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         tbl_ram_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= tbl_ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gamma_temporal_dither_core.sv
// Gamma mapping with per-pixel temporal error diffusion for a panel frame buffer.
//
// req_*: one word per accepted cycle (req_valid high, req_stall low). A load word
//   (req_action = 0) writes req_table_value into gamma entry req_table_index and
//   gives no result. A pixel word (req_action = 1) gives one rsp_* word: the
//   interleaved frame index and three saturated 10-bit channels.
// csr_*: register writes, always ready; write only while the block is idle.
//   Index 0 is dither_enable (reset 1), index 1 is four_row_mode (reset 0).
// Throughput is one word per cycle while req_stall is low. A pixel passes a
//   four-stage pipe (input register, table/remainder read, add/select,
//   saturate/pack output register) before it shows on rsp_*. Each channel has
//   its own copy of the gamma table so all three reads happen in the same cycle.
// After reset the remainder store is swept to zero, one entry per cycle, and
//   req_stall stays high until all PIXELS (4096) entries are cleared. Gamma
//   entries must be loaded before a pixel uses them.
// When rsp_stall is high with a result waiting, the whole pipe holds and
//   req_stall rises; nothing is dropped or repeated.
module gamma_temporal_dither_core
   import gtd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [TBL_AW-1:0]     req_table_index,
   input  logic [TBL_W-1:0]      req_table_value,
   input  logic [POS_W-1:0]      req_section_pos,
   input  logic [LANE_W-1:0]     req_lane,
   input  logic [CHAN_W-1:0]     req_chan_first,
   input  logic [CHAN_W-1:0]     req_chan_second,
   input  logic [CHAN_W-1:0]     req_chan_third,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FB_W-1:0]       rsp_fb_index,
   output logic [WORD_W-1:0]     rsp_pixel_word,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic                  csr_wdata
);

   // configuration
   logic dither_ff, dither_in;
   logic four_row_ff, four_row_in;

   // clearing sweep
   logic              clearing_ff, clearing_in;
   logic [SLOT_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic adv;

   // stage A
   logic              a_vld_ff;
   logic              a_pix_ff;
   logic [SLOT_W-1:0] a_slot_ff;
   logic [TBL_AW-1:0] a_tidx_ff;
   logic [TBL_W-1:0]  a_tval_ff;
   logic [CHAN_W-1:0] a_chan_ff [NUM_CHAN];
   logic [IDX_W-1:0]  req_idx;

   // stage B
   logic              b_vld_ff;
   logic              b_pix_ff;
   logic [SLOT_W-1:0] b_slot_ff;
   logic              b_fwd_ff;
   logic [REM_W-1:0]  b_fwd_rem_ff;
   logic [REM_W-1:0]  rem_rd_ff;
   logic [REM_W-1:0]  b_rem_cur;
   logic [REM_W-1:0]  b_rem_new;
   logic [TBL_W-1:0]  b_mapped [NUM_CHAN];
   logic [SUM_W-1:0]  b_val [NUM_CHAN];

   // stage C
   logic              c_vld_ff;
   logic [SLOT_W-1:0] c_slot_ff;
   logic [SUM_W-1:0]  c_val_ff [NUM_CHAN];

   // output register
   logic              o_vld_ff;
   logic [FB_W-1:0]   o_fb_ff;
   logic [WORD_W-1:0] o_word_ff;

   logic [REM_W-1:0]  rem_mem_ff [PIXELS];
   logic              rem_we;
   logic [SLOT_W-1:0] rem_waddr;
   logic [REM_W-1:0]  rem_wdata;

   tbl_wr_type tbl_wr;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      dither_in   = dither_ff;
      four_row_in = four_row_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DITHER_ENABLE: dither_in   = csr_wdata;
            CSR_FOUR_ROW_MODE: four_row_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff   <= 1'b1;
         four_row_ff <= 1'b0;
      end else begin
         dither_ff   <= dither_in;
         four_row_ff <= four_row_in;
      end
   end

   // ---------------------------------------------------------------- clear sweep
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == SLOT_W'(PIXELS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // whole pipe holds while a finished result is refused
   assign adv       = !(o_vld_ff && rsp_stall);
   assign req_stall = !adv || clearing_ff;

   // ---------------------------------------------------------------- stage A
   always_comb begin
      if (four_row_ff) begin
         req_idx = {req_section_pos, req_lane};
      end else begin
         req_idx = {1'b0, req_section_pos, req_lane[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid && !clearing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_pix_ff     <= (req_action == ACT_PIXEL);
         a_slot_ff    <= req_idx[SLOT_W-1:0];
         a_tidx_ff    <= req_table_index;
         a_tval_ff    <= req_table_value;
         a_chan_ff[0] <= req_chan_first;
         a_chan_ff[1] <= req_chan_second;
         a_chan_ff[2] <= req_chan_third;
      end
   end

   // ---------------------------------------------------------------- gamma tables
   assign tbl_wr.we   = adv && a_vld_ff && !a_pix_ff;
   assign tbl_wr.addr = a_tidx_ff;
   assign tbl_wr.data = a_tval_ff;

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_tbl
      gtd_gamma_ram u_ram (
         .clock   (clock),
         .wr      (tbl_wr),
         .rd_en   (adv),
         .rd_addr (a_chan_ff[c]),
         .rd_data (b_mapped[c])
      );
   end

   // ---------------------------------------------------------------- remainder store
   always_comb begin
      if (clearing_ff) begin
         rem_we    = 1'b1;
         rem_waddr = clr_cnt_ff;
         rem_wdata = '0;
      end else begin
         rem_we    = adv && b_vld_ff && b_pix_ff && dither_ff;
         rem_waddr = b_slot_ff;
         rem_wdata = b_rem_new;
      end
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem_ff[rem_waddr] <= rem_wdata;
      end
      if (adv) begin
         rem_rd_ff <= rem_mem_ff[a_slot_ff];
      end
   end

   // ---------------------------------------------------------------- stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         b_fwd_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
         // the read in stage A misses the write of the word just ahead
         b_fwd_ff <= a_vld_ff && a_pix_ff && b_vld_ff && b_pix_ff &&
                     (a_slot_ff == b_slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_pix_ff     <= a_pix_ff;
         b_slot_ff    <= a_slot_ff;
         b_fwd_rem_ff <= b_rem_new;
      end
   end

   assign b_rem_cur = b_fwd_ff ? b_fwd_rem_ff : rem_rd_ff;

   always_comb begin
      logic [SUM_W-1:0] sum;
      b_rem_new = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum = {1'b0, b_mapped[c]} +
               SUM_W'(b_rem_cur[c*FRACTION_BITS +: FRACTION_BITS]);
         b_rem_new[c*FRACTION_BITS +: FRACTION_BITS] = sum[FRACTION_BITS-1:0];
         if (dither_ff) begin
            b_val[c] = sum >> FRACTION_BITS;
         end else begin
            b_val[c] = {1'b0, b_mapped[c]};
         end
      end
   end

   // ---------------------------------------------------------------- stage C
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff && b_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_slot_ff <= b_slot_ff;
         for (int c = 0; c < NUM_CHAN; c++) begin
            c_val_ff[c] <= b_val[c];
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_fb_ff   <= FB_W'(c_slot_ff);
         o_word_ff <= {sat_chan(c_val_ff[0]), sat_chan(c_val_ff[1]),
                       sat_chan(c_val_ff[2])};
      end
   end

   assign rsp_valid      = o_vld_ff;
   assign rsp_fb_index   = o_fb_ff;
   assign rsp_pixel_word = o_word_ff;

   // ---------------------------------------------------------------- checks
   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !o_vld_ff && !a_vld_ff)
      else $error("pipeline busy during remainder sweep");

   a_fwd_matches_ahead: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && b_fwd_ff) |-> (c_vld_ff && (c_slot_ff == b_slot_ff)))
      else $error("remainder forward without matching word ahead");

   a_sweep_done_stays: assert property (@(posedge clock) disable iff (reset)
      !clearing_ff |=> !clearing_ff && $stable(clr_cnt_ff))
      else $error("remainder sweep restarted");

endmodule

FILE: test/gamma_temporal_dither_core_tb.sv
module gamma_temporal_dither_core_tb;
   import gtd_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int WAIT_MAX       = 13;
   localparam int SETTLE_CYCLES  = 12;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int NUM_PHASES     = 7;
   localparam int RAND_PER_PHASE = 130;
   localparam int PIX_CHAN_W     = NUM_CHAN * CHAN_W;

   localparam logic PHASE_DITHER [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam logic PHASE_FOUR   [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

   // chan[2] is the first byte, chan[0] the third; the same index picks the
   // 10-bit slot of the packed pixel word
   typedef struct {
      logic                                action;
      logic [TBL_AW-1:0]                   tbl_index;
      logic [TBL_W-1:0]                    tbl_value;
      logic [POS_W-1:0]                    pos;
      logic [LANE_W-1:0]                   lane;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]     chan;
   } feed_word_type;

   typedef struct packed {
      logic [FB_W-1:0]   fb_index;
      logic [WORD_W-1:0] pixel_word;
   } pixel_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = ACT_LOAD;
   logic [TBL_AW-1:0]    req_table_index = '0;
   logic [TBL_W-1:0]     req_table_value = '0;
   logic [POS_W-1:0]     req_section_pos = '0;
   logic [LANE_W-1:0]    req_lane = '0;
   logic [CHAN_W-1:0]    req_chan_first = '0;
   logic [CHAN_W-1:0]    req_chan_second = '0;
   logic [CHAN_W-1:0]    req_chan_third = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [FB_W-1:0]      rsp_fb_index;
   logic [WORD_W-1:0]    rsp_pixel_word;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_DITHER_ENABLE;
   logic                 csr_wdata = 1'b0;

   // shadow of the block's state
   logic [TBL_W-1:0]          gamma_copy [TBL_DEPTH];
   logic [FRACTION_BITS-1:0]  frac_copy [PIXELS][NUM_CHAN];
   logic                      dither_on;
   logic                      four_rows;

   feed_word_type      feed_words [$];
   pixel_result_type   expected_pixels [$];
   logic [TBL_AW-1:0] loaded_entries [$];
   bit              entry_loaded [TBL_DEPTH];

   logic            req_taken = 1'b0;
   logic            rsp_taken = 1'b0;
   int unsigned     idle_left = 0;
   int unsigned     hold_left = 0;
   int unsigned     send_burst = 0;
   int unsigned     recv_burst = 0;
   int              words_queued = 0;
   int              words_sent = 0;
   int              fault_count = 0;
   int              cycle_count = 0;

   gamma_temporal_dither_core DUT (.*);

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned draw_wait(inout int unsigned burst);
      if (burst != 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic pixel_result_type shade_pixel(input feed_word_type w);
      pixel_result_type r;
      int            lanes;
      int            slot;
      int            mapped;
      lanes = four_rows ? 4 : 2;
      slot = (int'(w.pos) * lanes + (int'(w.lane) & (lanes - 1))) % PIXELS;
      r.fb_index = FB_W'(slot);
      r.pixel_word = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         mapped = int'(gamma_copy[w.chan[k]]);
         if (dither_on) begin
            mapped += int'(frac_copy[slot][k]);
            frac_copy[slot][k] = FRACTION_BITS'(mapped);
            mapped = mapped >> FRACTION_BITS;
         end
         if (mapped > CHAN_MAX) mapped = CHAN_MAX;
         r.pixel_word[k*OUT_CHAN_W +: OUT_CHAN_W] = OUT_CHAN_W'(mapped);
      end
      return r;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endtask

   function automatic void add_load(input logic [TBL_AW-1:0] idx,
                                    input logic [TBL_W-1:0] val);
      feed_word_type w;
      w.action = ACT_LOAD;
      w.tbl_index = idx;
      w.tbl_value = val;
      w.pos = POS_W'($urandom);
      w.lane = LANE_W'($urandom);
      w.chan = PIX_CHAN_W'($urandom);
      if (!entry_loaded[idx]) begin
         entry_loaded[idx] = 1'b1;
         loaded_entries.push_back(idx);
      end
      feed_words.push_back(w);
      words_queued++;
   endfunction

   function automatic void add_pixel(input int pos, input int lane,
                                     input int first, input int second, input int third);
      feed_word_type w;
      w.action = ACT_PIXEL;
      w.tbl_index = TBL_AW'($urandom);
      w.tbl_value = TBL_W'($urandom);
      w.pos = POS_W'(pos);
      w.lane = LANE_W'(lane);
      w.chan = {CHAN_W'(first), CHAN_W'(second), CHAN_W'(third)};
      feed_words.push_back(w);
      words_queued++;
   endfunction

   // only bytes whose gamma entry has been loaded
   function automatic int pick_byte();
      return int'(loaded_entries[$urandom_range(0, loaded_entries.size() - 1)]);
   endfunction

   function automatic logic [TBL_W-1:0] rand_level();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return TBL_W'($urandom_range((1 << TBL_W) - 16, (1 << TBL_W) - 1));
         default: return TBL_W'($urandom);
      endcase
   endfunction

   function automatic void add_random();
      int unsigned pick;
      int          pos;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         add_load(TBL_AW'($urandom), rand_level());
      end else begin
         if (pick < 60) begin
            // hot slots: remainders keep building, and the wrapped alias in four-row mode
            pos = $urandom_range(0, 3) + (($urandom_range(0, 3) == 0) ? 1024 : 0);
         end else if (pick < 70) begin
            pos = $urandom_range(2044, 2047);
         end else begin
            pos = $urandom_range(0, (1 << POS_W) - 1);
         end
         add_pixel(pos, $urandom_range(0, 3), pick_byte(), pick_byte(), pick_byte());
      end
   endfunction

   function automatic void add_directed(input int phase);
      case (phase)
         0: begin
            add_load(0, '0);
            add_load(255, '1);
            add_load(1, 1);
            add_load(128, TBL_W'((1 << TBL_W) - 16));
            add_load(170, TBL_W'(14'h2aaa));
            add_load(85, TBL_W'(14'h1555));
            add_pixel(0, 0, 255, 255, 255);
            add_pixel(0, 0, 255, 128, 0);
            add_pixel(0, 0, 1, 1, 1);
            add_pixel(2047, 3, 170, 85, 0);
            add_pixel(2047, 2, 85, 170, 1);
         end
         1: begin
            add_pixel(0, 0, 255, 128, 1);
            add_pixel(0, 0, 0, 170, 85);
            add_pixel(2047, 1, 255, 255, 0);
         end
         2: begin
            add_pixel(1024, 0, 255, 1, 0);
            add_pixel(2047, 3, 170, 85, 128);
            add_pixel(1023, 3, 0, 255, 1);
         end
         3: begin
            add_pixel(1024, 0, 255, 255, 255);
            add_pixel(0, 0, 128, 1, 170);
            add_pixel(2047, 3, 255, 128, 85);
         end
         default: ;
      endcase
   endfunction

   task automatic settle();
      do @(negedge clock); while (words_sent != words_queued || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender: a random gap drawn by draw_wait before each word, hold while stalled
   always @(negedge clock) begin : feed
      int unsigned gap;
      feed_word_type  w;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else if (!req_valid || req_taken) begin
         gap = req_valid ? draw_wait(send_burst) : idle_left;
         if (gap == 0 && feed_words.size() != 0) begin
            w = feed_words.pop_front();
            req_valid <= 1'b1;
            req_action <= w.action;
            req_table_index <= w.tbl_index;
            req_table_value <= w.tbl_value;
            req_section_pos <= w.pos;
            req_lane <= w.lane;
            req_chan_first <= w.chan[2];
            req_chan_second <= w.chan[1];
            req_chan_third <= w.chan[0];
            idle_left = 0;
         end else begin
            req_valid <= 1'b0;
            idle_left = (gap == 0) ? 0 : gap - 1;
         end
      end
   end

   // receiver: stall for a random wait drawn by draw_wait after each taken word
   always @(negedge clock) begin : sink
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_taken) hold_left = draw_wait(recv_burst);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      feed_word_type    seen;
      pixel_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         dither_on = 1'b1;
         four_rows = 1'b0;
         foreach (frac_copy[i, k]) frac_copy[i][k] = '0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DITHER_ENABLE: dither_on = csr_wdata;
               CSR_FOUR_ROW_MODE: four_rows = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            words_sent++;
            seen.action = req_action;
            seen.tbl_index = req_table_index;
            seen.tbl_value = req_table_value;
            seen.pos = req_section_pos;
            seen.lane = req_lane;
            seen.chan = {req_chan_first, req_chan_second, req_chan_third};
            if (seen.action == ACT_LOAD) begin
               gamma_copy[seen.tbl_index] = seen.tbl_value;
            end else begin
               expected_pixels.push_back(shade_pixel(seen));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               note_fault($sformatf("unexpected word: fb_index %0d pixel_word %08h",
                                    rsp_fb_index, rsp_pixel_word));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_fb_index !== want.fb_index)
                  note_fault($sformatf("fb_index expected %0d got %0d",
                                       want.fb_index, rsp_fb_index));
               if (rsp_pixel_word !== want.pixel_word)
                  note_fault($sformatf("pixel_word at %0d expected %08h got %08h",
                                       want.fb_index, want.pixel_word, rsp_pixel_word));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         // drain everything before touching the registers
         if (p != 0) begin
            settle();
            write_csr(CSR_DITHER_ENABLE, PHASE_DITHER[p]);
            write_csr(CSR_FOUR_ROW_MODE, PHASE_FOUR[p]);
         end
         @(posedge clock);
         add_directed(p);
         for (int n = 0; n < RAND_PER_PHASE; n++) add_random();
      end
      settle();
      if (fault_count == 0 && expected_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/gtd_pkg.sv
hw/rtl/gtd_gamma_ram.sv
hw/rtl/gamma_temporal_dither_core.sv
test/gamma_temporal_dither_core_tb.sv
